// ===== src/fdcq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdcq_pkg
// types, codes and constants shared by the frame demux client queue block
// ----------------------------------------------------------------------------
package fdcq_pkg;

  // default sizes
  localparam int unsigned MAX_CLIENTS      = 4;
  localparam int unsigned DEF_CLIENT_COUNT = 4;
  localparam int unsigned DEF_QUEUE_DEPTH  = 128;
  localparam int unsigned DEF_MAX_FRAME    = 2048;

  // field widths
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned IPB_W       = 8;
  localparam int unsigned LEN_W       = 14;
  localparam int unsigned STORE_LEN_W = 12;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned CLIENT_W    = 2;
  localparam int unsigned ACTIVE_W    = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CLASS_W     = 2;
  localparam int unsigned STATUS_W    = 2;

  // classification constants
  localparam logic [MAC_W-1:0] BCAST_MAC    = '1;
  localparam logic [3:0]       MCAST_NIBBLE = 4'hE;
  localparam logic [LEN_W-1:0] MIN_MAC_LEN  = LEN_W'(6);
  localparam logic [LEN_W-1:0] MIN_IP_LEN   = LEN_W'(34);

  // item function codes
  localparam logic FUNC_ARRIVAL = 1'b0;
  localparam logic FUNC_READ    = 1'b1;

  // frame classes
  localparam logic [CLASS_W-1:0] CLASS_UNICAST   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_GROUP     = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_UNMATCHED = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_TOO_LONG  = 2'd3;

  // read status codes
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_LAST  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MORE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAC_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAC_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAC_C  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAC_D  = 3'd4;

  typedef struct packed {
    logic                func;
    logic [MAC_W-1:0]    dest_mac;
    logic [IPB_W-1:0]    ip_dest_first_byte;
    logic [LEN_W-1:0]    frame_length;
    logic [TAG_W-1:0]    frame_tag;
    logic [CLIENT_W-1:0] client_index;
  } in_item_t;

  typedef struct packed {
    logic [MAX_CLIENTS-1:0] enqueue_mask;
    logic [CLASS_W-1:0]     frame_class;
    logic [STATUS_W-1:0]    read_status;
    logic [STORE_LEN_W-1:0] read_length;
    logic [TAG_W-1:0]       read_tag;
  } out_item_t;

  // classified command from front to back
  typedef struct packed {
    logic                   is_read;
    logic [CLASS_W-1:0]     cls;
    logic [MAX_CLIENTS-1:0] target;
    logic                   read_ok;
    logic [STORE_LEN_W-1:0] length;
    logic [TAG_W-1:0]       tag;
    logic [CLIENT_W-1:0]    client_index;
  } cmd_t;

endpackage
`default_nettype wire

// ===== src/fdcq_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdcq_fifo
// two-entry register queue
// ----------------------------------------------------------------------------
module fdcq_fifo #(
  parameter int unsigned Width = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam logic [1:0] Depth = 2'd2;

  logic [Width-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == Depth);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= data_i;
  end

endmodule
`default_nettype wire

// ===== src/fdcq_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdcq_front
// configuration registers and frame classification
// ----------------------------------------------------------------------------
module fdcq_front #(
  parameter int unsigned CLIENT_COUNT = fdcq_pkg::DEF_CLIENT_COUNT,
  parameter int unsigned MAX_FRAME    = fdcq_pkg::DEF_MAX_FRAME
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [fdcq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [fdcq_pkg::MAC_W-1:0]       cfg_data_i,
  input  wire fdcq_pkg::in_item_t               item_i,
  output fdcq_pkg::cmd_t                        cmd_o
);

  localparam int unsigned AW = fdcq_pkg::ACTIVE_W;

  logic [AW-1:0]                  active_q;
  logic [fdcq_pkg::MAC_W-1:0]     mac_q [fdcq_pkg::MAX_CLIENTS];
  logic [AW-1:0]                  live_n;
  logic [fdcq_pkg::MAX_CLIENTS-1:0] live, hit, first_hit;
  logic                           too_long, mac_ok, ip_ok, group;
  logic                           found;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < fdcq_pkg::MAX_CLIENTS; i++) mac_q[i] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fdcq_pkg::REG_ACTIVE: active_q <= cfg_data_i[AW-1:0];
        fdcq_pkg::REG_MAC_A:  mac_q[0] <= cfg_data_i;
        fdcq_pkg::REG_MAC_B:  mac_q[1] <= cfg_data_i;
        fdcq_pkg::REG_MAC_C:  mac_q[2] <= cfg_data_i;
        fdcq_pkg::REG_MAC_D:  mac_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign live_n = (active_q > AW'(CLIENT_COUNT)) ? AW'(CLIENT_COUNT) : active_q;

  assign too_long = item_i.frame_length > fdcq_pkg::LEN_W'(MAX_FRAME);
  assign mac_ok   = item_i.frame_length >= fdcq_pkg::MIN_MAC_LEN;
  assign ip_ok    = item_i.frame_length >= fdcq_pkg::MIN_IP_LEN;
  assign group    = (mac_ok && item_i.dest_mac == fdcq_pkg::BCAST_MAC) ||
                    (ip_ok && item_i.ip_dest_first_byte[7:4] == fdcq_pkg::MCAST_NIBBLE);

  // lowest matching client wins
  always_comb begin
    live      = '0;
    hit       = '0;
    first_hit = '0;
    found     = 1'b0;
    for (int i = 0; i < CLIENT_COUNT; i++) begin
      live[i] = AW'(i) < live_n;
      hit[i]  = live[i] && mac_ok && (mac_q[i] == item_i.dest_mac);
      if (hit[i] && !found) begin
        first_hit[i] = 1'b1;
        found        = 1'b1;
      end
    end
  end

  always_comb begin
    cmd_o.is_read      = (item_i.func == fdcq_pkg::FUNC_READ);
    cmd_o.read_ok      = {1'b0, item_i.client_index} < live_n;
    cmd_o.length       = item_i.frame_length[fdcq_pkg::STORE_LEN_W-1:0];
    cmd_o.tag          = item_i.frame_tag;
    cmd_o.client_index = item_i.client_index;
    priority if (too_long) begin
      cmd_o.cls    = fdcq_pkg::CLASS_TOO_LONG;
      cmd_o.target = '0;
    end else if (found) begin
      cmd_o.cls    = fdcq_pkg::CLASS_UNICAST;
      cmd_o.target = first_hit;
    end else if (group) begin
      cmd_o.cls    = fdcq_pkg::CLASS_GROUP;
      cmd_o.target = live;
    end else begin
      cmd_o.cls    = fdcq_pkg::CLASS_UNMATCHED;
      cmd_o.target = '0;
    end
  end

endmodule
`default_nettype wire

// ===== src/fdcq_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdcq_back
// per-client descriptor rings: enqueue, dequeue and result build
// ----------------------------------------------------------------------------
module fdcq_back #(
  parameter int unsigned CLIENT_COUNT = fdcq_pkg::DEF_CLIENT_COUNT,
  parameter int unsigned QUEUE_DEPTH  = fdcq_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_valid_i,
  input  wire fdcq_pkg::cmd_t     cmd_i,
  output logic                    cmd_pop_o,
  input  wire logic               out_full_i,
  output logic                    out_push_o,
  output fdcq_pkg::out_item_t     out_item_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned EW = fdcq_pkg::STORE_LEN_W + fdcq_pkg::TAG_W;
  localparam logic [PW-1:0] LastIdx = PW'(QUEUE_DEPTH - 1);

  logic [PW-1:0] head_q [CLIENT_COUNT];
  logic [PW-1:0] tail_q [CLIENT_COUNT];
  logic [PW-1:0] head_inc [CLIENT_COUNT];
  logic [PW-1:0] tail_inc [CLIENT_COUNT];
  logic [CLIENT_COUNT-1:0] q_full, q_empty, wr_en, rd_en;
  logic [EW-1:0] rdata_q [CLIENT_COUNT];

  logic                          accept, is_enq;
  logic                          pend_q;
  logic [fdcq_pkg::STATUS_W-1:0] pend_status_q, rd_status;
  logic [fdcq_pkg::CLIENT_W-1:0] pend_ci_q;
  logic [EW-1:0]                 sel_rdata;

  assign accept    = cmd_valid_i && !pend_q && !out_full_i;
  assign cmd_pop_o = accept;
  assign is_enq    = accept && !cmd_i.is_read;

  always_comb begin
    rd_status = fdcq_pkg::STATUS_EMPTY;
    for (int i = 0; i < CLIENT_COUNT; i++) begin
      head_inc[i] = (head_q[i] == LastIdx) ? '0 : head_q[i] + PW'(1);
      tail_inc[i] = (tail_q[i] == LastIdx) ? '0 : tail_q[i] + PW'(1);
      q_full[i]   = (head_inc[i] == tail_q[i]);
      q_empty[i]  = (head_q[i] == tail_q[i]);
      wr_en[i]    = is_enq && cmd_i.target[i] && !q_full[i];
      rd_en[i]    = accept && cmd_i.is_read && cmd_i.read_ok &&
                    (cmd_i.client_index == fdcq_pkg::CLIENT_W'(i)) && !q_empty[i];
      if (rd_en[i]) begin
        rd_status = (tail_inc[i] == head_q[i]) ? fdcq_pkg::STATUS_LAST
                                               : fdcq_pkg::STATUS_MORE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CLIENT_COUNT; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      pend_q        <= 1'b0;
      pend_status_q <= fdcq_pkg::STATUS_EMPTY;
      pend_ci_q     <= '0;
    end else begin
      for (int i = 0; i < CLIENT_COUNT; i++) begin
        if (wr_en[i]) head_q[i] <= head_inc[i];
        if (rd_en[i]) tail_q[i] <= tail_inc[i];
      end
      pend_q <= accept && cmd_i.is_read;
      if (accept && cmd_i.is_read) begin
        pend_status_q <= rd_status;
        pend_ci_q     <= cmd_i.client_index;
      end
    end
  end

  // one descriptor memory per client
  for (genvar g = 0; g < CLIENT_COUNT; g++) begin : g_ring
    logic [EW-1:0] mem_q [QUEUE_DEPTH];
    always_ff @(posedge clk_i) begin
      if (wr_en[g]) mem_q[head_q[g]] <= {cmd_i.length, cmd_i.tag};
      if (rd_en[g]) rdata_q[g] <= mem_q[tail_q[g]];
    end
  end

  always_comb begin
    sel_rdata = '0;
    for (int i = 0; i < CLIENT_COUNT; i++) begin
      if (pend_ci_q == fdcq_pkg::CLIENT_W'(i)) sel_rdata = rdata_q[i];
    end
  end

  assign out_push_o = is_enq || pend_q;

  always_comb begin
    out_item_o = '0;
    if (pend_q) begin
      out_item_o.frame_class = fdcq_pkg::CLASS_UNICAST;
      out_item_o.read_status = pend_status_q;
      if (pend_status_q != fdcq_pkg::STATUS_EMPTY) begin
        out_item_o.read_length = sel_rdata[EW-1:fdcq_pkg::TAG_W];
        out_item_o.read_tag    = sel_rdata[fdcq_pkg::TAG_W-1:0];
      end
    end else begin
      out_item_o.frame_class = cmd_i.cls;
      for (int i = 0; i < CLIENT_COUNT; i++) out_item_o.enqueue_mask[i] = wr_en[i];
    end
  end

endmodule
`default_nettype wire

// ===== src/frame_demux_client_queues.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frame_demux_client_queues
// sorts frame descriptors into per-client ring queues by destination mac
// ----------------------------------------------------------------------------
// results: an arrival result goes into the result queue as the back accepts it,
//   a read result only after the registered memory read
// throughput: one arrival per cycle while the result queue has room and no read
//   is pending; the registered read port holds off new commands after a read
// reset: all queues empty, registers cleared, no clearing pass needed
// ----------------------------------------------------------------------------
module frame_demux_client_queues #(
  parameter int unsigned CLIENT_COUNT = fdcq_pkg::DEF_CLIENT_COUNT,
  parameter int unsigned QUEUE_DEPTH  = fdcq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned MAX_FRAME    = fdcq_pkg::DEF_MAX_FRAME
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [fdcq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [fdcq_pkg::MAC_W-1:0]     cfg_data_i,
  // item input side
  input  wire logic                           push,
  output logic                                full,
  input  wire fdcq_pkg::in_item_t             in_item_i,
  // result side
  output logic                                empty,
  input  wire logic                           pop,
  output fdcq_pkg::out_item_t                 result_o
);

  fdcq_pkg::cmd_t      front_cmd, back_cmd;
  fdcq_pkg::out_item_t back_result;
  logic                cmd_empty, cmd_pop;
  logic                res_full, res_push;

  // registers are always writable; the user must write them only while idle, as the block does not enforce it
  assign cfg_ready_o = 1'b1;

  // front: holds registers, classifies each item as it is pushed
  fdcq_front #(
    .CLIENT_COUNT (CLIENT_COUNT),
    .MAX_FRAME    (MAX_FRAME)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (in_item_i),
    .cmd_o       (front_cmd)
  );

  // short command queue decouples the front from the ring logic
  fdcq_fifo #(
    .Width ($bits(fdcq_pkg::cmd_t))
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  // back: enqueues into and dequeues from the client rings
  fdcq_back #(
    .CLIENT_COUNT (CLIENT_COUNT),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (res_full),
    .out_push_o  (res_push),
    .out_item_o  (back_result)
  );

  // result queue: the back keeps working while a result waits
  fdcq_fifo #(
    .Width ($bits(fdcq_pkg::out_item_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_result),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

`ifndef SYNTH
  // a unicast hit lands in at most one queue
  a_unicast_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.frame_class == fdcq_pkg::CLASS_UNICAST) |->
      $onehot0(result_o.enqueue_mask))
    else $error("unicast result enqueued into more than one client");

  // dropped classes never enqueue
  a_drop_no_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.frame_class == fdcq_pkg::CLASS_TOO_LONG ||
                result_o.frame_class == fdcq_pkg::CLASS_UNMATCHED)) |->
      (result_o.enqueue_mask == '0))
    else $error("dropped frame shows an enqueue");

  // an empty read carries no descriptor
  a_empty_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.read_status == fdcq_pkg::STATUS_EMPTY) |->
      (result_o.read_length == '0 && result_o.read_tag == '0))
    else $error("empty read returned descriptor data");

  // a delivered read never reports an enqueue
  a_read_no_enqueue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.read_status != fdcq_pkg::STATUS_EMPTY) |->
      (result_o.enqueue_mask == '0 &&
       result_o.frame_class == fdcq_pkg::CLASS_UNICAST))
    else $error("read result mixed with arrival fields");
`endif

endmodule
`default_nettype wire

// ===== tb/fdcq_sb_pkg.sv =====
// ----------------------------------------------------------------------------
// fdcq_sb_pkg
// scoreboard for the frame demux client queues: keeps its own copy of the
// client registers and descriptor rings, works out the outcome of every
// accepted item and checks the block's results against them in order
// ----------------------------------------------------------------------------
package fdcq_sb_pkg;
  import fdcq_pkg::*;

  class demux_scoreboard;
    logic [ACTIVE_W-1:0]    active;
    logic [MAC_W-1:0]       mac [MAX_CLIENTS];
    int unsigned            head [MAX_CLIENTS];
    int unsigned            tail [MAX_CLIENTS];
    logic [STORE_LEN_W-1:0] entry_len [MAX_CLIENTS][DEF_QUEUE_DEPTH];
    logic [TAG_W-1:0]       entry_tag [MAX_CLIENTS][DEF_QUEUE_DEPTH];
    out_item_t              pending_outcomes [$];
    int unsigned            mismatches;

    function new();
      active     = '0;
      mismatches = 0;
      for (int c = 0; c < MAX_CLIENTS; c++) begin
        mac[c]  = '0;
        head[c] = 0;
        tail[c] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAC_W-1:0] data);
      case (idx)
        REG_ACTIVE: active = data[ACTIVE_W-1:0];
        REG_MAC_A:  mac[0] = data;
        REG_MAC_B:  mac[1] = data;
        REG_MAC_C:  mac[2] = data;
        REG_MAC_D:  mac[3] = data;
        default: ;
      endcase
    endfunction

    // ring keeps one slot free, so a full ring refuses the descriptor
    function bit store_descriptor(int unsigned c, logic [LEN_W-1:0] len,
                                  logic [TAG_W-1:0] tag);
      int unsigned nh;
      nh = (head[c] + 1) % DEF_QUEUE_DEPTH;
      if (nh == tail[c]) return 1'b0;
      entry_len[c][head[c]] = len[STORE_LEN_W-1:0];
      entry_tag[c][head[c]] = tag;
      head[c] = nh;
      return 1'b1;
    endfunction

    function void note_item(in_item_t it);
      out_item_t           r;
      int unsigned         n;
      bit                  hit;
      bit                  group;
      logic [CLIENT_W-1:0] ci;
      r   = '0;
      hit = 1'b0;
      ci  = it.client_index;
      n   = (active > DEF_CLIENT_COUNT) ? DEF_CLIENT_COUNT : active;
      if (it.func == FUNC_ARRIVAL) begin
        if (it.frame_length > DEF_MAX_FRAME) begin
          r.frame_class = CLASS_TOO_LONG;
        end else begin
          if (it.frame_length >= MIN_MAC_LEN) begin
            for (int i = 0; i < n; i++) begin
              if (!hit && mac[i] == it.dest_mac) begin
                hit = 1'b1;
                r.frame_class = CLASS_UNICAST;
                r.enqueue_mask[i] = store_descriptor(i, it.frame_length, it.frame_tag);
              end
            end
          end
          if (!hit) begin
            group = (it.frame_length >= MIN_MAC_LEN && it.dest_mac == BCAST_MAC) ||
                    (it.frame_length >= MIN_IP_LEN &&
                     it.ip_dest_first_byte[7:4] == MCAST_NIBBLE);
            if (group) begin
              r.frame_class = CLASS_GROUP;
              for (int i = 0; i < n; i++)
                r.enqueue_mask[i] = store_descriptor(i, it.frame_length, it.frame_tag);
            end else begin
              r.frame_class = CLASS_UNMATCHED;
            end
          end
        end
      end else begin
        r.read_status = STATUS_EMPTY;
        if (ci < n && tail[ci] != head[ci]) begin
          r.read_length = entry_len[ci][tail[ci]];
          r.read_tag    = entry_tag[ci][tail[ci]];
          tail[ci]      = (tail[ci] + 1) % DEF_QUEUE_DEPTH;
          r.read_status = (tail[ci] == head[ci]) ? STATUS_LAST : STATUS_MORE;
        end
      end
      pending_outcomes.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_outcomes.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", got));
      end else begin
        want = pending_outcomes.pop_front();
        if (got.enqueue_mask !== want.enqueue_mask)
          report($sformatf("enqueue_mask got %h want %h", got.enqueue_mask,
                           want.enqueue_mask));
        if (got.frame_class !== want.frame_class)
          report($sformatf("frame_class got %h want %h", got.frame_class,
                           want.frame_class));
        if (got.read_status !== want.read_status)
          report($sformatf("read_status got %h want %h", got.read_status,
                           want.read_status));
        if (got.read_length !== want.read_length)
          report($sformatf("read_length got %h want %h", got.read_length,
                           want.read_length));
        if (got.read_tag !== want.read_tag)
          report($sformatf("read_tag got %h want %h", got.read_tag, want.read_tag));
      end
    endtask
  endclass

endpackage

// ===== tb/tb_frame_demux_client_queues.sv =====
// ----------------------------------------------------------------------------
// tb_frame_demux_client_queues
// self-checking bench: directed frames and reads, then random phases under
// several client settings, with random idling on both sides, a long result
// hold-off that backs the block up, and in-order checking of every result
// ----------------------------------------------------------------------------
module tb_frame_demux_client_queues;
  timeunit 1ns;
  timeprecision 1ps;

  import fdcq_pkg::*;
  import fdcq_sb_pkg::*;

  // idle cycles without any handshake before the run is abandoned
  localparam int unsigned STALL_LIMIT = 5000;
  // index with no register behind it, written once to show it is ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MAC_W-1:0]     cfg_data;
  logic                 push;
  logic                 full;
  in_item_t             in_item;
  logic                 empty;
  logic                 pop;
  out_item_t            result;

  demux_scoreboard sb;
  int unsigned     rx_hold_cycles;
  int unsigned     idle_cycles;

  frame_demux_client_queues i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ---- item builders -------------------------------------------------------

  function automatic in_item_t arrival(logic [MAC_W-1:0] dest, logic [IPB_W-1:0] ipb,
                                       logic [LEN_W-1:0] len, logic [TAG_W-1:0] tag);
    in_item_t it;
    it                    = '0;
    it.func               = FUNC_ARRIVAL;
    it.dest_mac           = dest;
    it.ip_dest_first_byte = ipb;
    it.frame_length       = len;
    it.frame_tag          = tag;
    it.client_index       = CLIENT_W'($urandom);
    return it;
  endfunction

  // fields other than the client index are noise for a read
  function automatic in_item_t read_req(logic [CLIENT_W-1:0] ci);
    in_item_t it;
    it              = arrival(MAC_W'({$urandom, $urandom}), IPB_W'($urandom),
                              LEN_W'($urandom), TAG_W'($urandom));
    it.func         = FUNC_READ;
    it.client_index = ci;
    return it;
  endfunction

  // random item biased towards the client macs, broadcast, multicast bytes
  // and the length boundaries so that every class turns up often
  function automatic in_item_t draw_item(int unsigned read_pct);
    in_item_t    it;
    int unsigned sel;
    it = read_req(CLIENT_W'($urandom));
    if ($urandom_range(99) >= read_pct) begin
      it.func = FUNC_ARRIVAL;
      sel = $urandom_range(99);
      if (sel < 45) it.dest_mac = sb.mac[$urandom_range(MAX_CLIENTS - 1)];
      else if (sel < 60) it.dest_mac = BCAST_MAC;
      if ($urandom_range(3) == 0) it.ip_dest_first_byte[7:4] = MCAST_NIBBLE;
      sel = $urandom_range(99);
      if (sel < 8) begin
        it.frame_length = LEN_W'($urandom_range(5));
      end else if (sel < 16) begin
        it.frame_length = LEN_W'($urandom_range(6, 33));
      end else if (sel < 22) begin
        it.frame_length = LEN_W'($urandom_range(DEF_MAX_FRAME + 1, 16383));
      end else if (sel < 30) begin
        case ($urandom_range(5))
          0: it.frame_length = MIN_MAC_LEN - LEN_W'(1);
          1: it.frame_length = MIN_MAC_LEN;
          2: it.frame_length = MIN_IP_LEN - LEN_W'(1);
          3: it.frame_length = MIN_IP_LEN;
          4: it.frame_length = LEN_W'(DEF_MAX_FRAME);
          default: it.frame_length = LEN_W'(DEF_MAX_FRAME + 1);
        endcase
      end else begin
        it.frame_length = LEN_W'($urandom_range(MIN_IP_LEN, DEF_MAX_FRAME));
      end
    end
    return it;
  endfunction

  // ---- drivers -------------------------------------------------------------

  // inputs move on the falling edge, handshakes are judged on the rising one
  task automatic send_item(in_item_t it, int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      push = 1'b0;
    end
    @(negedge clk_i);
    push    = 1'b1;
    in_item = it;
    do @(posedge clk_i); while (full);
    sb.note_item(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAC_W-1:0] data);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // active count goes in the low bits, the rest of the word is junk
  task automatic set_active(logic [ACTIVE_W-1:0] count);
    logic [MAC_W-1:0] word;
    word = MAC_W'({$urandom, $urandom});
    word[ACTIVE_W-1:0] = count;
    write_reg(REG_ACTIVE, word);
  endtask

  task automatic apply_settings(logic [ACTIVE_W-1:0] count, logic [MAC_W-1:0] a,
                                logic [MAC_W-1:0] b, logic [MAC_W-1:0] c,
                                logic [MAC_W-1:0] d);
    set_active(count);
    write_reg(REG_MAC_A, a);
    write_reg(REG_MAC_B, b);
    write_reg(REG_MAC_C, c);
    write_reg(REG_MAC_D, d);
  endtask

  // sender goes quiet until every outstanding result has been taken
  task automatic drain();
    @(negedge clk_i);
    push = 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // random phase; every 40 items the sender may switch to back-to-back pushes
  task automatic run_phase(int unsigned count, int unsigned read_pct,
                           int unsigned max_gap);
    bit burst;
    burst = 1'b0;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 40 == 0) burst = ($urandom_range(3) == 0);
      send_item(draw_item(read_pct), burst ? 0 : $urandom_range(max_gap));
    end
  endtask

  // ---- result side ---------------------------------------------------------

  // pops with random gaps; a hold-off request from the main sequence is
  // served before the next result, counted here in clock cycles
  initial begin : result_sink
    int unsigned gap;
    int unsigned hold;
    int unsigned taken;
    bit          burst;
    pop   = 1'b0;
    taken = 0;
    burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken % 50 == 0) burst = ($urandom_range(3) == 0);
      gap  = burst ? 0 : $urandom_range(5);
      hold = rx_hold_cycles;
      rx_hold_cycles = 0;
      repeat (gap + hold) begin
        @(negedge clk_i);
        pop = 1'b0;
      end
      @(negedge clk_i);
      pop = 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check_result(result);
      taken++;
    end
  end

  // ---- watchdog ------------------------------------------------------------

  initial idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---- main sequence -------------------------------------------------------

  initial begin : main_sequence
    logic [MAC_W-1:0] mac_b;
    logic [MAC_W-1:0] mac_c;
    sb             = new();
    push           = 1'b0;
    in_item        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_ACTIVE;
    cfg_data       = '0;
    rx_hold_cycles = 0;
    rst_ni         = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: no client active, every frame finds nowhere to go
    send_item(arrival(BCAST_MAC, 8'h00, 14'd64, 16'h1234), 0);
    send_item(arrival('0, 8'hE1, 14'd64, 16'h4321), 1);
    send_item(read_req(2'd0), 0);
    send_item(read_req(2'd3), 2);
    drain();

    // four clients, client 0 on the all-zero mac
    mac_b = MAC_W'({$urandom, $urandom});
    mac_c = MAC_W'({$urandom, $urandom});
    apply_settings(3'd4, '0, mac_b, mac_c, MAC_W'({$urandom, $urandom}));
    write_reg(REG_UNUSED, MAC_W'({$urandom, $urandom}));

    // directed: length limits, short frames, group delivery, read statuses
    send_item(arrival('0, 8'h00, MIN_MAC_LEN, 16'h0000), 0);
    send_item(arrival(mac_b, 8'hFF, LEN_W'(DEF_MAX_FRAME), 16'hFFFF), 0);
    send_item(arrival(mac_b, 8'h00, LEN_W'(DEF_MAX_FRAME + 1), 16'h0001), 1);
    send_item(arrival('1, 8'hE0, 14'h3FFF, 16'hFFFF), 0);
    send_item(arrival('0, 8'h00, MIN_MAC_LEN - LEN_W'(1), 16'h0002), 3);  // too short to match
    send_item(arrival('1, 8'hE0, 14'd0, 16'h0003), 0);            // zero length
    send_item(arrival('1, 8'h00, MIN_MAC_LEN, 16'hA5A5), 0);      // broadcast to all
    send_item(arrival(MAC_W'({$urandom, $urandom}), 8'hE0, MIN_IP_LEN, 16'h5A5A), 2);
    send_item(arrival(MAC_W'({$urandom, $urandom}), 8'hEF, MIN_IP_LEN - LEN_W'(1),
                      16'h0004), 0);
    send_item(arrival(MAC_W'({$urandom, $urandom}), 8'hF0, 14'd100, 16'h0005), 0);
    send_item(arrival(MAC_W'({$urandom, $urandom}), 8'hDF, 14'd100, 16'h0006), 5);
    send_item(arrival(mac_c, 8'h00, 14'd1500, 16'h0007), 0);
    send_item(read_req(2'd0), 0);
    send_item(read_req(2'd0), 1);
    send_item(read_req(2'd0), 0);
    send_item(read_req(2'd0), 0);                                 // now empty
    send_item(read_req(2'd1), 4);
    send_item(read_req(2'd3), 0);
    send_item(read_req(2'd3), 0);
    send_item(arrival(sb.mac[3], 8'hE5, 14'd40, 16'h0008), 0);    // match beats multicast
    drain();

    // results held back for a long stretch while items keep coming
    rx_hold_cycles = 300;
    run_phase(150, 30, 0);
    run_phase(150, 40, 5);
    drain();

    // count above the client limit, all-ones mac on client 0 takes
    // broadcasts, duplicate mac on client 2 loses to client 1
    mac_b = MAC_W'({$urandom, $urandom});
    apply_settings(3'd7, '1, mac_b, mac_b, MAC_W'({$urandom, $urandom}));
    run_phase(250, 40, 5);
    drain();

    // two clients: reads of clients 2 and 3 see nothing, their rings stay
    apply_settings(3'd2, MAC_W'({$urandom, $urandom}), MAC_W'({$urandom, $urandom}),
                   MAC_W'({$urandom, $urandom}), MAC_W'({$urandom, $urandom}));
    run_phase(250, 45, 5);
    drain();

    // single client
    set_active(3'd1);
    run_phase(200, 35, 5);
    drain();

    // no client at all, written explicitly this time
    set_active(3'd0);
    run_phase(20, 50, 3);
    drain();

    // all four back with their old rings; overfill client 0 first, then
    // broadcasts land only in the rings that still have room
    apply_settings(3'd4, MAC_W'({$urandom, $urandom}), MAC_W'({$urandom, $urandom}),
                   MAC_W'({$urandom, $urandom}), MAC_W'({$urandom, $urandom}));
    for (int k = 0; k < DEF_QUEUE_DEPTH + 2; k++)
      send_item(arrival(sb.mac[0], IPB_W'($urandom),
                        LEN_W'($urandom_range(MIN_MAC_LEN, DEF_MAX_FRAME)),
                        TAG_W'($urandom)), $urandom_range(2));
    for (int k = 0; k < 10; k++)
      send_item(arrival(BCAST_MAC, IPB_W'($urandom),
                        LEN_W'($urandom_range(MIN_MAC_LEN, DEF_MAX_FRAME)),
                        TAG_W'($urandom)), $urandom_range(5));
    run_phase(160, 55, 5);
    drain();

    // let any stray result show itself before the verdict
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
src/fdcq_pkg.sv
src/fdcq_fifo.sv
src/fdcq_front.sv
src/fdcq_back.sv
src/frame_demux_client_queues.sv
tb/fdcq_sb_pkg.sv
tb/tb_frame_demux_client_queues.sv
